// ===== rtl/cpos_pkg.sv =====
package cpos_pkg;

	// Field widths.
	localparam int COORD_W  = 16;
	localparam int DIST_W   = COORD_W + 1;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int PROD_W   = 2 * DIFF_W;
	localparam int DOT_W    = PROD_W + 1;
	localparam int L2_W     = PROD_W - 1;
	localparam int T_FRAC   = 16;
	localparam int T_INT    = 8;
	localparam int T_W      = T_INT + T_FRAC;
	localparam int Q_W      = T_W - 1;
	localparam int REM_W    = L2_W + T_FRAC;
	localparam int MX_W     = DIFF_W + T_W;
	localparam int SUM_W    = MX_W - T_FRAC + 1;
	localparam int SR_W     = PROD_W;
	localparam int SQ_STEPS = SR_W / 2;
	localparam int CFG_IDX_W = 3;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END_Y   = 3'd3;

	// Limits of t and of the coordinates.
	localparam logic signed [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};
	localparam logic signed [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};
	localparam logic signed [T_W-1:0] T_ONE = T_W'(1 << T_FRAC);
	localparam logic signed [MX_W-1:0] ROUND_HALF = MX_W'(1 << (T_FRAC - 1));
	localparam logic signed [SUM_W-1:0] COORD_MAX = SUM_W'((1 << (COORD_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] COORD_MIN = -SUM_W'(1 << (COORD_W - 1));
	localparam logic [SR_W-1:0] DIST_MAX = SR_W'((1 << DIST_W) - 1);

	// Item data that rides along the divider chain.
	typedef struct packed {
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic                      clamp;
		logic                      neg;
		logic                      zero;
		logic                      ovf;
	} side_t;

	// One divider cell's data: partial remainder, divisor and quotient so far.
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [L2_W-1:0]  l2;
		logic [Q_W-1:0]   q;
		side_t            side;
	} div_t;

	// One square-root cell's data.
	typedef struct packed {
		logic [SR_W-1:0]           x;
		logic [SR_W-1:0]           r;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
	} sq_t;

	// Saturate a wide sum to the coordinate range.
	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
		logic signed [COORD_W-1:0] res;
		if (v > COORD_MAX) begin
			res = COORD_MAX[COORD_W-1:0];
		end else if (v < COORD_MIN) begin
			res = COORD_MIN[COORD_W-1:0];
		end else begin
			res = v[COORD_W-1:0];
		end
		return res;
	endfunction

endpackage

// ===== rtl/cpos_if.sv =====
// Query request channel.
interface cpos_req_if;
	import cpos_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic                      clamp_to_segment;

	modport source (output valid, output point_x, output point_y, output clamp_to_segment,
		input ready);
	modport sink (input valid, input point_x, input point_y, input clamp_to_segment,
		output ready);
endinterface

// Result channel.
interface cpos_res_if;
	import cpos_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] closest_x;
	logic signed [COORD_W-1:0] closest_y;
	logic [DIST_W-1:0]         distance;

	modport source (output valid, output closest_x, output closest_y, output distance,
		input ready);
	modport sink (input valid, input closest_x, input closest_y, input distance,
		output ready);
endinterface

// ===== rtl/closest_point_on_segment.sv =====
// Throughput: one request per cycle while the result side is ready, set by the 23 divider
// cells and 17 square-root cells that each pass data to the next cell every cycle unless stalled.
// A stalled output holds each full stage behind it; earlier bubbles still fill.
// Reset clears all valid bits and the four line registers to zero.
module closest_point_on_segment (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [cpos_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cpos_pkg::COORD_W-1:0]         cfg_data,
	cpos_req_if.sink                             req_ch,
	cpos_res_if.source                           res_ch
);
	import cpos_pkg::*;

	// Line registers.
	logic signed [COORD_W-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
	logic signed [DIFF_W-1:0]  dx, dy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			end_x_q   <= '0;
			end_y_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_X: start_x_q <= cfg_data;
				REG_START_Y: start_y_q <= cfg_data;
				REG_END_X:   end_x_q   <= cfg_data;
				REG_END_Y:   end_y_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Direction vector; the user must change the line only while the block is idle (not enforced here).
	assign dx = DIFF_W'(end_x_q) - DIFF_W'(start_x_q);
	assign dy = DIFF_W'(end_y_q) - DIFF_W'(start_y_q);

	// Stage valids and advance enables.
	logic v_s1, v_s2, v_s3, v_s5, v_s6, v_s7, v_s8, v_s9, v_s11;
	logic en_s1, en_s2, en_s3, en_s5, en_s6, en_s7, en_s8, en_s9, en_s11;
	logic  dv_v  [0:Q_W];
	logic  dv_en [0:Q_W];
	div_t  dv_d  [0:Q_W];
	logic  sq_v  [0:SQ_STEPS];
	logic  sq_en [0:SQ_STEPS];
	sq_t   sq_d  [0:SQ_STEPS];

	assign en_s11 = !v_s11 || res_ch.ready;
	assign sq_en[SQ_STEPS] = !sq_v[SQ_STEPS] || en_s11;
	assign en_s9  = !v_s9 || sq_en[0];
	assign en_s8  = !v_s8 || en_s9;
	assign en_s7  = !v_s7 || en_s8;
	assign en_s6  = !v_s6 || en_s7;
	assign en_s5  = !v_s5 || en_s6;
	assign dv_en[Q_W] = !dv_v[Q_W] || en_s5;
	assign en_s3  = !v_s3 || dv_en[0];
	assign en_s2  = !v_s2 || en_s3;
	assign en_s1  = !v_s1 || en_s2;
	assign req_ch.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s11 <= 1'b0;
			dv_v[0] <= 1'b0;
			sq_v[0] <= 1'b0;
		end else begin
			if (en_s1)  v_s1 <= req_ch.valid;
			if (en_s2)  v_s2 <= v_s1;
			if (en_s3)  v_s3 <= v_s2;
			if (dv_en[0]) dv_v[0] <= v_s3;
			if (en_s5)  v_s5 <= dv_v[Q_W];
			if (en_s6)  v_s6 <= v_s5;
			if (en_s7)  v_s7 <= v_s6;
			if (en_s8)  v_s8 <= v_s7;
			if (en_s9)  v_s9 <= v_s8;
			if (sq_en[0]) sq_v[0] <= v_s9;
			if (en_s11) v_s11 <= sq_v[SQ_STEPS];
		end
	end

	// Stage 1: offset of the query from the line start.
	logic signed [DIFF_W-1:0]  ax_s1, ay_s1;
	logic signed [COORD_W-1:0] px_s1, py_s1;
	logic                      clamp_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ax_s1    <= DIFF_W'(req_ch.point_x) - DIFF_W'(start_x_q);
			ay_s1    <= DIFF_W'(req_ch.point_y) - DIFF_W'(start_y_q);
			px_s1    <= req_ch.point_x;
			py_s1    <= req_ch.point_y;
			clamp_s1 <= req_ch.clamp_to_segment;
		end
	end

	// Stage 2: products for the dot product and the squared length.
	logic signed [PROD_W-1:0]  pax_s2, pay_s2, pdx_s2, pdy_s2;
	logic signed [COORD_W-1:0] px_s2, py_s2;
	logic                      clamp_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			pax_s2   <= PROD_W'(ax_s1) * PROD_W'(dx);
			pay_s2   <= PROD_W'(ay_s1) * PROD_W'(dy);
			pdx_s2   <= PROD_W'(dx) * PROD_W'(dx);
			pdy_s2   <= PROD_W'(dy) * PROD_W'(dy);
			px_s2    <= px_s1;
			py_s2    <= py_s1;
			clamp_s2 <= clamp_s1;
		end
	end

	// Stage 3: dot product as sign and magnitude, and squared length.
	logic signed [DOT_W-1:0]   dot_c, dmag_c;
	logic [L2_W-1:0]           mag_s3, l2_s3;
	logic                      neg_s3;
	logic signed [COORD_W-1:0] px_s3, py_s3;
	logic                      clamp_s3;

	always_comb begin
		dot_c  = DOT_W'(pax_s2) + DOT_W'(pay_s2);
		dmag_c = dot_c[DOT_W-1] ? -dot_c : dot_c;
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			mag_s3   <= dmag_c[L2_W-1:0];
			neg_s3   <= dot_c[DOT_W-1];
			l2_s3    <= L2_W'(pdx_s2) + L2_W'(pdy_s2);
			px_s3    <= px_s2;
			py_s3    <= py_s2;
			clamp_s3 <= clamp_s2;
		end
	end

	// Stage 4: divider setup, overflow of the integer part, degenerate line.
	always_ff @(posedge clk) begin
		if (dv_en[0]) begin
			dv_d[0].rem        <= REM_W'(mag_s3) << T_FRAC;
			dv_d[0].l2         <= l2_s3;
			dv_d[0].q          <= '0;
			dv_d[0].side.px    <= px_s3;
			dv_d[0].side.py    <= py_s3;
			dv_d[0].side.clamp <= clamp_s3;
			dv_d[0].side.neg   <= neg_s3;
			dv_d[0].side.zero  <= l2_s3 == '0;
			dv_d[0].side.ovf   <= (mag_s3 >> (T_INT - 1)) >= l2_s3;
		end
	end

	// Divider chain, most significant quotient bit first.
	for (genvar k = 1; k <= Q_W; k++) begin : g_div
		if (k < Q_W) begin : g_en
			assign dv_en[k] = !dv_v[k] || dv_en[k+1];
		end
		cpos_div_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (dv_en[k]),
			.vin   (dv_v[k-1]),
			.din   (dv_d[k-1]),
			.ix    (5'(Q_W - k)),
			.vout  (dv_v[k]),
			.dout  (dv_d[k])
		);
	end
	assign dv_en[0] = !dv_v[0] || dv_en[1];

	// Stage 5: signed, saturated and optionally clamped t.
	div_t                      dq;
	logic signed [T_W-1:0]     t_raw, t_cl;
	logic signed [T_W-1:0]     t_s5;
	logic signed [COORD_W-1:0] px_s5, py_s5;

	always_comb begin
		dq = dv_d[Q_W];
		if (dq.side.zero) begin
			t_raw = '0;
		end else if (dq.side.ovf) begin
			t_raw = dq.side.neg ? T_MIN : T_MAX;
		end else begin
			t_raw = dq.side.neg ? -$signed({1'b0, dq.q}) : $signed({1'b0, dq.q});
		end
		t_cl = t_raw;
		if (dq.side.clamp && t_raw < 0) begin
			t_cl = '0;
		end else if (dq.side.clamp && t_raw > T_ONE) begin
			t_cl = T_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			t_s5  <= t_cl;
			px_s5 <= dq.side.px;
			py_s5 <= dq.side.py;
		end
	end

	// Stage 6: direction scaled by t.
	logic signed [MX_W-1:0]    mx_s6, my_s6;
	logic signed [COORD_W-1:0] px_s6, py_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			mx_s6 <= MX_W'(dx) * MX_W'(t_s5);
			my_s6 <= MX_W'(dy) * MX_W'(t_s5);
			px_s6 <= px_s5;
			py_s6 <= py_s5;
		end
	end

	// Stage 7: round to coordinate units, add the start and saturate.
	logic signed [MX_W-1:0]    rx_c, ry_c;
	logic signed [SUM_W-1:0]   sx_c, sy_c;
	logic signed [COORD_W-1:0] cx_s7, cy_s7, px_s7, py_s7;

	always_comb begin
		rx_c = (mx_s6 + ROUND_HALF) >>> T_FRAC;
		ry_c = (my_s6 + ROUND_HALF) >>> T_FRAC;
		sx_c = SUM_W'(rx_c) + SUM_W'(start_x_q);
		sy_c = SUM_W'(ry_c) + SUM_W'(start_y_q);
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			cx_s7 <= sat_coord(sx_c);
			cy_s7 <= sat_coord(sy_c);
			px_s7 <= px_s6;
			py_s7 <= py_s6;
		end
	end

	// Stage 8: error vector from the closest point to the query.
	logic signed [DIFF_W-1:0]  ex_s8, ey_s8;
	logic signed [COORD_W-1:0] cx_s8, cy_s8;

	always_ff @(posedge clk) begin
		if (en_s8) begin
			ex_s8 <= DIFF_W'(px_s7) - DIFF_W'(cx_s7);
			ey_s8 <= DIFF_W'(py_s7) - DIFF_W'(cy_s7);
			cx_s8 <= cx_s7;
			cy_s8 <= cy_s7;
		end
	end

	// Stage 9: squares of the error.
	logic [SR_W-1:0]           ex2_s9, ey2_s9;
	logic signed [COORD_W-1:0] cx_s9, cy_s9;

	always_ff @(posedge clk) begin
		if (en_s9) begin
			ex2_s9 <= SR_W'(PROD_W'(ex_s8) * PROD_W'(ex_s8));
			ey2_s9 <= SR_W'(PROD_W'(ey_s8) * PROD_W'(ey_s8));
			cx_s9  <= cx_s8;
			cy_s9  <= cy_s8;
		end
	end

	// Stage 10: squared distance into the root chain.
	always_ff @(posedge clk) begin
		if (sq_en[0]) begin
			sq_d[0].x  <= ex2_s9 + ey2_s9;
			sq_d[0].r  <= '0;
			sq_d[0].cx <= cx_s9;
			sq_d[0].cy <= cy_s9;
		end
	end

	// Square-root chain, highest bit first.
	for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sqrt
		if (k < SQ_STEPS) begin : g_en
			assign sq_en[k] = !sq_v[k] || sq_en[k+1];
		end
		cpos_sqrt_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (sq_en[k]),
			.vin   (sq_v[k-1]),
			.din   (sq_d[k-1]),
			.kbit  (5'(SQ_STEPS - k)),
			.vout  (sq_v[k]),
			.dout  (sq_d[k])
		);
	end
	assign sq_en[0] = !sq_v[0] || sq_en[1];

	// Stage 11: round the root to nearest, saturate, and hold the result.
	sq_t              sf;
	logic [SR_W-1:0]  rf_c;
	logic signed [COORD_W-1:0] cx_s11, cy_s11;
	logic [DIST_W-1:0]         dist_s11;

	always_comb begin
		sf   = sq_d[SQ_STEPS];
		rf_c = sf.r + SR_W'(sf.x > sf.r);
	end

	always_ff @(posedge clk) begin
		if (en_s11) begin
			cx_s11   <= sf.cx;
			cy_s11   <= sf.cy;
			dist_s11 <= (rf_c > DIST_MAX) ? DIST_MAX[DIST_W-1:0] : rf_c[DIST_W-1:0];
		end
	end

	assign res_ch.valid     = v_s11;
	assign res_ch.closest_x = cx_s11;
	assign res_ch.closest_y = cy_s11;
	assign res_ch.distance  = dist_s11;
endmodule

// ===== rtl/cpos_div_cell.sv =====
// One restoring-division cell: decides one quotient bit per request.
module cpos_div_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vin,
	input  cpos_pkg::div_t       din,
	input  logic [4:0]           ix,
	output logic                 vout,
	output cpos_pkg::div_t       dout
);
	import cpos_pkg::*;

	logic [5:0]       sh;
	logic [REM_W-1:0] hi;
	logic [REM_W-1:0] sub;
	logic             take;

	// Compare the remainder against the divisor at this bit's weight.
	// The remainder already carries the fraction bits of t.
	always_comb begin
		sh   = 6'(ix);
		hi   = din.rem >> sh;
		sub  = REM_W'(din.l2) << sh;
		take = hi >= REM_W'(din.l2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout.rem  <= take ? din.rem - sub : din.rem;
			dout.l2   <= din.l2;
			dout.q    <= {din.q[Q_W-2:0], take};
			dout.side <= din.side;
		end
	end
endmodule

// ===== rtl/cpos_sqrt_cell.sv =====
// One digit-by-digit square-root cell: settles one result bit per request.
module cpos_sqrt_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vin,
	input  cpos_pkg::sq_t        din,
	input  logic [4:0]           kbit,
	output logic                 vout,
	output cpos_pkg::sq_t        dout
);
	import cpos_pkg::*;

	logic [SR_W-1:0] bitv;
	logic [SR_W-1:0] trial;
	logic            take;

	// Try to add this bit to the root.
	always_comb begin
		bitv  = SR_W'(1) << {kbit, 1'b0};
		trial = din.r + bitv;
		take  = din.x >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout.x  <= take ? din.x - trial : din.x;
			dout.r  <= take ? (din.r >> 1) + bitv : din.r >> 1;
			dout.cx <= din.cx;
			dout.cy <= din.cy;
		end
	end
endmodule

// ===== tb/sv/cpos_checker.sv =====
// Watches the request and result channels and the configuration port,
// predicts each closest point and distance, and compares them in order.
module cpos_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cpos_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cpos_pkg::COORD_W-1:0]   cfg_data,
	cpos_req_if                            req_ch,
	cpos_res_if                            res_ch,
	output int                             errors,
	output int                             pending
);
	import cpos_pkg::*;

	typedef struct {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic [DIST_W-1:0]         dlen;
	} closest_t;

	closest_t closest_q[$];
	longint line_sx, line_sy, line_ex, line_ey;

	// Integer square root rounded to nearest.
	function automatic longint unsigned root_nearest(input longint unsigned v);
		longint unsigned r, bt, x;
		r = 0;
		bt = 64'd1 << 62;
		x = v;
		while (bt > x) bt >>= 2;
		while (bt != 0) begin
			if (x >= r + bt) begin
				x -= r + bt;
				r = (r >> 1) + bt;
			end else begin
				r >>= 1;
			end
			bt >>= 2;
		end
		if (x > r) r++;
		return r;
	endfunction

	function automatic longint sat_range(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// Projects the query onto the line and measures the distance.
	function automatic closest_t project_point(input longint px, input longint py,
		input logic clamp);
		closest_t res;
		longint dx, dy, ax, ay, dot, t, tm, cx, cy, ex, ey;
		longint unsigned l2, mag, q, r, d2, root;
		longint t_hi, t_lo;
		t_hi = (64'sd1 << (T_W - 1)) - 1;
		t_lo = -t_hi - 1;
		dx = line_ex - line_sx;
		dy = line_ey - line_sy;
		ax = px - line_sx;
		ay = py - line_sy;
		l2 = dx * dx + dy * dy;
		dot = ax * dx + ay * dy;
		t = 0;
		if (l2 != 0) begin
			mag = dot < 0 ? -dot : dot;
			q = mag / l2;
			r = mag % l2;
			if (q >= (64'd1 << (T_INT - 1))) tm = t_hi + 1;
			else tm = (q << T_FRAC) + (r << T_FRAC) / l2;
			t = sat_range(dot < 0 ? -tm : tm, t_lo, t_hi);
		end
		if (clamp) t = sat_range(t, 0, 64'sd1 << T_FRAC);
		cx = line_sx + ((dx * t + (64'sd1 << (T_FRAC - 1))) >>> T_FRAC);
		cy = line_sy + ((dy * t + (64'sd1 << (T_FRAC - 1))) >>> T_FRAC);
		cx = sat_range(cx, -32768, 32767);
		cy = sat_range(cy, -32768, 32767);
		ex = px - cx;
		ey = py - cy;
		d2 = ex * ex + ey * ey;
		root = root_nearest(d2);
		if (root > (64'd1 << DIST_W) - 1) root = (64'd1 << DIST_W) - 1;
		res.cx = cx[COORD_W-1:0];
		res.cy = cy[COORD_W-1:0];
		res.dlen = root[DIST_W-1:0];
		return res;
	endfunction

	assign pending = closest_q.size();

	// Line registers follow the configuration port.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_sx <= 0;
			line_sy <= 0;
			line_ex <= 0;
			line_ey <= 0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_X: begin
					line_sx <= longint'($signed(cfg_data));
				end
				REG_START_Y: begin
					line_sy <= longint'($signed(cfg_data));
				end
				REG_END_X: begin
					line_ex <= longint'($signed(cfg_data));
				end
				REG_END_Y: begin
					line_ey <= longint'($signed(cfg_data));
				end
				default: begin
				end
			endcase
		end
	end

	initial errors = 0;

	// Predict on each accepted request and compare each accepted result.
	always @(posedge clk) begin
		closest_t got, exp_r;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			closest_q.push_back(project_point(longint'(req_ch.point_x),
				longint'(req_ch.point_y), req_ch.clamp_to_segment));
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.cx = res_ch.closest_x;
			got.cy = res_ch.closest_y;
			got.dlen = res_ch.distance;
			if (closest_q.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				exp_r = closest_q.pop_front();
				if (got.cx !== exp_r.cx) begin
					$error("closest_x expected %0d actual %0d", exp_r.cx, got.cx);
					errors++;
				end
				if (got.cy !== exp_r.cy) begin
					$error("closest_y expected %0d actual %0d", exp_r.cy, got.cy);
					errors++;
				end
				if (got.dlen !== exp_r.dlen) begin
					$error("distance expected %0d actual %0d", exp_r.dlen, got.dlen);
					errors++;
				end
			end
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
	import cpos_pkg::*;

	localparam int SETTLE = 60;
	localparam int STALL_LIMIT = 20000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COORD_W-1:0]   cfg_data;
	int                   errors;
	int                   pending;
	int                   send_idle_pct;
	int                   recv_stall_pct;
	int                   quiet_cycles;

	cpos_req_if req_ch ();
	cpos_res_if res_ch ();

	closest_point_on_segment u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req_ch   (req_ch.sink),
		.res_ch   (res_ch.source)
	);

	cpos_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req_ch   (req_ch),
		.res_ch   (res_ch),
		.errors   (errors),
		.pending  (pending)
	);

	initial clk = 0;
	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// Result side stalls at random.
	always @(negedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog on cycles without any handshake.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Sends one request, idling first as the current phase asks.
	task automatic send_query(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
		input logic clamp);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid = 0;
			@(negedge clk);
		end
		req_ch.valid = 1;
		req_ch.point_x = px;
		req_ch.point_y = py;
		req_ch.clamp_to_segment = clamp;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		@(negedge clk);
		req_ch.valid = 0;
	endtask

	// Waits for the pipeline to drain, then loads a new line.
	task automatic load_line(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
		input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey);
		logic [COORD_W-1:0] vals[4];
		vals = '{sx, sy, ex, ey};
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		for (int i = 0; i < 4; i++) begin
			cfg_we = 1;
			cfg_index = CFG_IDX_W'(i);
			cfg_data = vals[i];
			@(negedge clk);
		end
		// Indexes past the last register must be ignored.
		cfg_index = CFG_IDX_W'(REG_END_Y + 1);
		cfg_data = COORD_W'($urandom);
		@(negedge clk);
		cfg_index = {CFG_IDX_W{1'b1}};
		cfg_data = COORD_W'($urandom);
		@(negedge clk);
		cfg_we = 0;
	endtask

	// Random query: mostly full range, some extremes, some near the origin.
	task automatic random_query();
		logic [COORD_W-1:0] px, py;
		int pick;
		pick = $urandom_range(7);
		px = COORD_W'($urandom);
		py = COORD_W'($urandom);
		if (pick == 0) begin
			px = $urandom_range(1) ? 16'h8000 : 16'h7fff;
			py = $urandom_range(1) ? 16'h8000 : 16'h7fff;
		end else if (pick <= 2) begin
			px = COORD_W'(int'($urandom_range(255)) - 128);
			py = COORD_W'(int'($urandom_range(255)) - 128);
		end
		send_query(px, py, 1'($urandom_range(1)));
	endtask

	initial begin
		logic [COORD_W-1:0] lines[6][4];
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_START_X;
		cfg_data = 0;
		req_ch.valid = 0;
		req_ch.point_x = 0;
		req_ch.point_y = 0;
		req_ch.clamp_to_segment = 0;
		res_ch.ready = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		quiet_cycles = 0;
		repeat (2) @(negedge clk);
		arst_n = 1;

		// Degenerate line straight after reset: the start point is returned.
		send_query(16'h0000, 16'h0000, 0);
		send_query(16'h7fff, 16'h7fff, 0);
		send_query(16'h8000, 16'h8000, 1);

		// Short horizontal segment: clamped and unclamped on both sides.
		load_line(16'h0000, 16'h0000, 16'h0010, 16'h0000);
		send_query(16'h0008, 16'h0040, 1);
		send_query(16'hffc0, 16'h0010, 1);
		send_query(16'h0100, 16'hfff0, 1);
		send_query(16'hffc0, 16'h0010, 0);
		send_query(16'h0100, 16'hfff0, 0);
		send_query(16'h7fff, 16'h8000, 0);
		send_query(16'h8000, 16'h7fff, 0);
		send_query(16'h7fff, 16'h7fff, 1);

		// Extreme diagonal: the largest distances and saturated points.
		load_line(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
		send_query(16'h8000, 16'h7fff, 0);
		send_query(16'h7fff, 16'h8000, 1);
		send_query(16'h0000, 16'h0000, 0);
		send_query(16'h8000, 16'h8000, 0);
		send_query(16'h7fff, 16'h7fff, 1);
		send_query(16'h5555, 16'haaaa, 0);
		send_query(16'haaaa, 16'h5555, 1);

		lines[0] = '{16'h7fff, 16'h8000, 16'h8000, 16'h7fff};
		lines[1] = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
		lines[2] = '{16'h0000, 16'h0000, 16'h0001, 16'h0001};
		lines[3] = '{16'h1234, 16'hfedc, 16'h1234, 16'h4000};
		lines[4] = '{COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
			COORD_W'($urandom)};
		lines[5] = '{COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
			COORD_W'($urandom)};

		// Random part: each line runs through every idling phase.
		for (int l = 0; l < 6; l++) begin
			load_line(lines[l][0], lines[l][1], lines[l][2], lines[l][3]);
			for (int ph = 0; ph < 4; ph++) begin
				send_idle_pct = (ph == 1) ? 84 : (ph == 3) ? 17 : 0;
				recv_stall_pct = (ph == 2) ? 84 : (ph == 3) ? 17 : 0;
				for (int n = 0; n < 56; n++) begin
					random_query();
					// Once, hold off until every outstanding result is back.
					if (l == 2 && ph == 0 && n == 20) begin
						while (pending != 0) @(negedge clk);
					end
				end
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;

		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
